// ===== src/ipt_pkg.sv =====
// ----------------------------------------------------------------------------
// ipt_pkg
// Shared types and constants for the path-table parser.
// ----------------------------------------------------------------------------
package ipt_pkg;

   localparam int unsigned MaxDirsDefault    = 128;
   localparam int unsigned QueueDepthDefault = 4;

   localparam logic [1:0] KIND_NAME  = 2'd0;
   localparam logic [1:0] KIND_ENTRY = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   // record layout offsets
   localparam logic [8:0] OFF_LENGTH = 9'd0;
   localparam logic [8:0] OFF_LBA_LO = 9'd2;
   localparam logic [8:0] OFF_LBA_HI = 9'd5;
   localparam logic [8:0] OFF_PARENT = 9'd6;
   localparam logic [8:0] OFF_NAME   = 9'd8;

   // one classified byte: up to three results, emitted name, entry, end
   typedef struct packed {
      logic        has_name;
      logic        has_entry;
      logic        has_end;
      logic [7:0]  name_char;
      logic [31:0] extent_lba;
      logic [7:0]  parent_dir;
      logic [7:0]  dir_number;
      logic [7:0]  name_length;
      logic [7:0]  entry_count;
      logic        cut_short;
   } op_type;

   typedef struct packed {
      logic   push;
      op_type op;
   } push_type;

endpackage

// ===== src/ipt_req_if.sv =====
// ----------------------------------------------------------------------------
// ipt_req_if
// Sector byte channel: one word per byte.
// ----------------------------------------------------------------------------
interface ipt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       sector_end;

   modport source (output valid, output data_byte, output sector_end, input ready);
   modport sink   (input valid, input data_byte, input sector_end, output ready);
endinterface

// ===== src/ipt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ipt_rsp_if
// Result channel: name bytes, completed entries and the end-of-table word.
// ----------------------------------------------------------------------------
interface ipt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  name_char;
   logic [31:0] extent_lba;
   logic [7:0]  parent_dir;
   logic [7:0]  dir_number;
   logic [7:0]  name_length;
   logic [7:0]  entry_count;
   logic        cut_short;
   logic        last;

   modport source (output valid, output kind, output name_char, output extent_lba,
                   output parent_dir, output dir_number, output name_length,
                   output entry_count, output cut_short, output last, input ready);
   modport sink   (input valid, input kind, input name_char, input extent_lba,
                   input parent_dir, input dir_number, input name_length,
                   input entry_count, input cut_short, input last, output ready);
endinterface

// ===== src/ipt_front.sv =====
// ----------------------------------------------------------------------------
// ipt_front
// Record parser: tracks the position in the record and classifies each byte.
// ----------------------------------------------------------------------------
module ipt_front #(
   parameter int unsigned MAX_DIRS = ipt_pkg::MaxDirsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [7:0]        in_byte,
   input  logic              in_sector_end,
   input  logic              queue_full,
   output logic              in_ready,
   output ipt_pkg::push_type push_out
);

   logic [8:0]  offset_ff,  offset_in;
   logic [7:0]  length_ff,  length_in;
   logic [31:0] lba_ff,     lba_in;
   logic [7:0]  parent_ff,  parent_in;
   logic [7:0]  entries_ff, entries_in;
   logic        ended_ff,   ended_in;

   logic        accept;
   logic [8:0]  total;
   logic [8:0]  offset_inc;
   logic        entry_done;
   logic        max_end;
   logic [8:0]  entries_wide;
   ipt_pkg::op_type op;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      offset_in  = offset_ff;
      length_in  = length_ff;
      lba_in     = lba_ff;
      parent_in  = parent_ff;
      entries_in = entries_ff;
      ended_in   = ended_ff;
      op         = '0;
      total      = '0;
      offset_inc = '0;
      entry_done = 1'b0;
      max_end    = 1'b0;
      entries_wide = '0;

      if (!ended_ff) begin
         if (offset_ff == ipt_pkg::OFF_LENGTH && in_byte == 8'd0) begin
            // zero length byte terminates the table
            op.has_end     = 1'b1;
            op.entry_count = entries_ff;
            ended_in       = 1'b1;
         end else begin
            if (offset_ff == ipt_pkg::OFF_LENGTH) begin
               length_in = in_byte;
               lba_in    = '0;
               parent_in = '0;
            end else if (offset_ff >= ipt_pkg::OFF_LBA_LO &&
                         offset_ff <= ipt_pkg::OFF_LBA_HI) begin
               unique case (offset_ff[1:0])
                  2'd2:    lba_in = lba_ff | {24'd0, in_byte};
                  2'd3:    lba_in = lba_ff | {16'd0, in_byte, 8'd0};
                  2'd0:    lba_in = lba_ff | {8'd0, in_byte, 16'd0};
                  default: lba_in = lba_ff | {in_byte, 24'd0};
               endcase
            end else if (offset_ff == ipt_pkg::OFF_PARENT) begin
               parent_in = in_byte;
            end else if (offset_ff >= ipt_pkg::OFF_NAME &&
                         offset_ff < ipt_pkg::OFF_NAME + {1'b0, length_ff}) begin
               op.has_name  = 1'b1;
               op.name_char = in_byte;
            end

            total      = ipt_pkg::OFF_NAME + {1'b0, length_in} + {8'd0, length_in[0]};
            offset_inc = offset_ff + 9'd1;
            entry_done = offset_inc >= total;
            offset_in  = entry_done ? 9'd0 : offset_inc;

            if (entry_done) begin
               op.has_entry   = 1'b1;
               op.extent_lba  = lba_in;
               op.parent_dir  = parent_in;
               op.dir_number  = entries_ff + 8'd1;
               op.name_length = length_in;
               entries_in     = entries_ff + 8'd1;
               entries_wide   = {1'b0, entries_in};
               max_end        = entries_wide >= 9'(MAX_DIRS);
            end

            if (max_end || in_sector_end) begin
               op.has_end     = 1'b1;
               op.entry_count = entries_in;
               op.cut_short   = !max_end && (offset_in != 9'd0);
               ended_in       = 1'b1;
            end
         end
      end
   end

   assign push_out.push = accept && (op.has_name || op.has_entry || op.has_end);
   assign push_out.op   = op;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff  <= '0;
         length_ff  <= '0;
         lba_ff     <= '0;
         parent_ff  <= '0;
         entries_ff <= '0;
         ended_ff   <= 1'b0;
      end else if (accept) begin
         offset_ff  <= offset_in;
         length_ff  <= length_in;
         lba_ff     <= lba_in;
         parent_ff  <= parent_in;
         entries_ff <= entries_in;
         ended_ff   <= ended_in;
      end
   end

endmodule

// ===== src/ipt_queue.sv =====
// ----------------------------------------------------------------------------
// ipt_queue
// Small FIFO of classified bytes between parser and result sequencer.
// ----------------------------------------------------------------------------
module ipt_queue #(
   parameter int unsigned DEPTH = ipt_pkg::QueueDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  ipt_pkg::push_type push_in,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output ipt_pkg::op_type   head
);

   localparam int unsigned PtrWidth = $clog2(DEPTH);
   localparam int unsigned CntWidth = $clog2(DEPTH + 1);

   ipt_pkg::op_type     slot_ff [DEPTH];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff,  count_in;
   logic                do_push, do_pop;

   assign full    = count_ff == CntWidth'(DEPTH);
   assign empty   = count_ff == '0;
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push_in.push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_in.op;
      end
   end

endmodule

// ===== src/ipt_back.sv =====
// ----------------------------------------------------------------------------
// ipt_back
// Result sequencer: expands each queued byte into words, one per ready cycle.
// ----------------------------------------------------------------------------
module ipt_back (
   input  logic            clock,
   input  logic            reset,
   input  logic            head_valid,
   input  ipt_pkg::op_type head,
   output logic            pop,
   ipt_rsp_if.source       rsp_chan
);

   logic [2:0]  done_ff, done_in;
   logic [2:0]  pending;
   logic [2:0]  sel;
   logic        load;
   logic        is_last;

   logic        valid_ff;
   logic [1:0]  kind_ff,  kind_in;
   logic [7:0]  char_ff,  char_in;
   logic [31:0] lba_ff,   lba_in;
   logic [7:0]  parent_ff, parent_in;
   logic [7:0]  number_ff, number_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  count_ff,  count_in;
   logic        cut_ff,    cut_in;
   logic        last_ff;

   // bit 0 name, bit 1 entry, bit 2 end
   assign pending = {head.has_end, head.has_entry, head.has_name} & ~done_ff;

   always_comb begin
      priority if (pending[0]) begin
         sel = 3'b001;
      end else if (pending[1]) begin
         sel = 3'b010;
      end else begin
         sel = 3'b100;
      end
   end

   assign is_last = (pending & ~sel) == 3'b000;
   assign load    = head_valid && (!valid_ff || rsp_chan.ready);
   assign pop     = load && is_last;
   assign done_in = is_last ? 3'b000 : (done_ff | sel);

   always_comb begin
      kind_in   = ipt_pkg::KIND_END;
      char_in   = '0;
      lba_in    = '0;
      parent_in = '0;
      number_in = '0;
      length_in = '0;
      count_in  = '0;
      cut_in    = 1'b0;
      unique case (sel)
         3'b001: begin
            kind_in = ipt_pkg::KIND_NAME;
            char_in = head.name_char;
         end
         3'b010: begin
            kind_in   = ipt_pkg::KIND_ENTRY;
            lba_in    = head.extent_lba;
            parent_in = head.parent_dir;
            number_in = head.dir_number;
            length_in = head.name_length;
         end
         default: begin
            count_in = head.entry_count;
            cut_in   = head.cut_short;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         done_ff  <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         done_ff  <= done_in;
      end else if (rsp_chan.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff   <= kind_in;
         char_ff   <= char_in;
         lba_ff    <= lba_in;
         parent_ff <= parent_in;
         number_ff <= number_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         cut_ff    <= cut_in;
         last_ff   <= is_last;
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.kind        = kind_ff;
   assign rsp_chan.name_char   = char_ff;
   assign rsp_chan.extent_lba  = lba_ff;
   assign rsp_chan.parent_dir  = parent_ff;
   assign rsp_chan.dir_number  = number_ff;
   assign rsp_chan.name_length = length_ff;
   assign rsp_chan.entry_count = count_ff;
   assign rsp_chan.cut_short   = cut_ff;
   assign rsp_chan.last        = last_ff;

endmodule

// ===== src/iso9660_path_table_parser_core.sv =====
// ----------------------------------------------------------------------------
// iso9660_path_table_parser_core
// Streaming parser for one type-L path-table sector.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan takes one sector byte per word, with sector_end on the last byte.
//   rsp_chan gives a name byte word per name byte, an entry word when a record
//   completes, and one end word (entry count, cut-short flag) when the table
//   ends on a zero length byte, at MAX_DIRS records or at sector end. last
//   marks the final word caused by a given byte. Bytes after the end word are
//   taken and dropped until reset.
// Timing:
//   A byte is accepted every cycle while the queue has room. Its first word
//   goes through the queue and the output register to rsp_chan. A byte making
//   k words (k up to 3) holds the result sequencer for them, so sustained rate
//   is one byte per cycle with a ready receiver; the queue absorbs record ends.
// Reset (synchronous) clears parser state, the queue and the output register.
// A stalled receiver holds the output word; the queue fills, then req ready
// drops until words drain.
// ----------------------------------------------------------------------------
module iso9660_path_table_parser_core #(
   parameter int unsigned MAX_DIRS    = ipt_pkg::MaxDirsDefault,
   parameter int unsigned QUEUE_DEPTH = ipt_pkg::QueueDepthDefault
) (
   input logic       clock,
   input logic       reset,
   ipt_req_if.sink   req_chan,
   ipt_rsp_if.source rsp_chan
);

   ipt_pkg::push_type push;
   ipt_pkg::op_type   head;
   logic              queue_full;
   logic              queue_empty;
   logic              pop;

   ipt_front #(
      .MAX_DIRS (MAX_DIRS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_chan.valid),
      .in_byte       (req_chan.data_byte),
      .in_sector_end (req_chan.sector_end),
      .queue_full    (queue_full),
      .in_ready      (req_chan.ready),
      .push_out      (push)
   );

   ipt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .pop     (pop),
      .full    (queue_full),
      .empty   (queue_empty),
      .head    (head)
   );

   ipt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!queue_empty),
      .head       (head),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
